/* src/arte_pkg.sv */
// ----------------------------------------------------------------------------
// arte_pkg
// Types, codes and constants shared by the ARP receive table engine.
// ----------------------------------------------------------------------------
package arte_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IP_ASSIGNED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC   = 2'd2;

  localparam logic [15:0] HW_TYPE_ETH = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  typedef enum logic [1:0] {
    CLS_SHORT,
    CLS_NOT_ETH,
    CLS_NOT_IP,
    CLS_ARP
  } cls_t;

  typedef enum logic [2:0] {
    STAT_SHORT      = 3'd0,
    STAT_NOT_ETH    = 3'd1,
    STAT_NOT_IP     = 3'd2,
    STAT_UPD_OTHER  = 3'd3,
    STAT_IGNORED    = 3'd4,
    STAT_UPD_OURS   = 3'd5,
    STAT_ADDED      = 3'd6,
    STAT_FULL       = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } back_state_t;

  typedef struct packed {
    cls_t        cls;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } pkt_t;

endpackage

/* src/arte_front.sv */
// ----------------------------------------------------------------------------
// arte_front
// Accepts received packets, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module arte_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           frame_short,
  input  logic [15:0]    hw_type,
  input  logic [15:0]    proto_type,
  input  logic [7:0]     hw_len,
  input  logic [7:0]     proto_len,
  input  logic [15:0]    opcode,
  input  logic [47:0]    sender_mac,
  input  logic [31:0]    sender_ip,
  input  logic [31:0]    target_ip,
  input  logic           q_full,
  output logic           q_push,
  output arte_pkg::pkt_t q_item
);
  import arte_pkg::*;

  cls_t cls;

  always_comb begin
    priority if (frame_short) begin
      cls = CLS_SHORT;
    end else if (hw_type != HW_TYPE_ETH) begin
      cls = CLS_NOT_ETH;
    end else if (proto_type != PROTO_IPV4) begin
      cls = CLS_NOT_IP;
    end else begin
      cls = CLS_ARP;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.cls        = cls;
    q_item.hw_type    = hw_type;
    q_item.proto_type = proto_type;
    q_item.hw_len     = hw_len;
    q_item.proto_len  = proto_len;
    q_item.opcode     = opcode;
    q_item.sender_mac = sender_mac;
    q_item.sender_ip  = sender_ip;
    q_item.target_ip  = target_ip;
  end

endmodule

/* src/arte_queue.sv */
// ----------------------------------------------------------------------------
// arte_queue
// Short queue of classified packets between front and back.
// ----------------------------------------------------------------------------
module arte_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  arte_pkg::pkt_t item_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output arte_pkg::pkt_t item_out
);
  import arte_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pkt_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign item_out = slots[rptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= item_in;
    end
  end

endmodule

/* src/arte_back.sv */
// ----------------------------------------------------------------------------
// arte_back
// Walks the address table, updates or adds the sender and builds the result.
// ----------------------------------------------------------------------------
module arte_back #(
  parameter int TABLE_ENTRIES = arte_pkg::DEF_TABLE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  arte_pkg::pkt_t q_item,
  output logic           q_pop,
  input  logic [31:0]    local_ip,
  input  logic           ip_assigned,
  input  logic [47:0]    local_mac,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     status,
  output logic           table_full,
  output logic           reply_valid,
  output logic [15:0]    reply_hw_type,
  output logic [15:0]    reply_proto_type,
  output logic [7:0]     reply_hw_len,
  output logic [7:0]     reply_proto_len,
  output logic [15:0]    reply_opcode,
  output logic [47:0]    reply_sender_mac,
  output logic [31:0]    reply_sender_ip,
  output logic [47:0]    reply_target_mac,
  output logic [31:0]    reply_target_ip
);
  import arte_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  back_state_t   state;
  back_state_t   state_next;
  pkt_t          pkt;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] cmp_idx;
  logic          cmp_valid;
  logic          hit_found;
  logic [IW-1:0] hit_idx;

  logic [79:0]   mem [TABLE_ENTRIES];
  logic [79:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] mem_waddr;
  logic          mem_we;

  logic          scan_hit;
  logic          scan_done;
  logic          issue;
  logic          load;
  logic          ours;
  logic          full;
  logic          do_add;
  logic          reply;
  status_t       stat_next;
  status_t       stat;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.cls == CLS_ARP) ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    scan_hit  = cmp_valid && (rd_data[79:48] == pkt.sender_ip);
    scan_done = (scan_idx == fill_count);
    rd_addr   = scan_idx[IW-1:0];
    q_pop     = (state == ST_IDLE) && q_valid;
    issue     = (state == ST_SCAN) && !scan_hit && !scan_done;
    load      = (state == ST_DECIDE) && (!out_valid || out_ready);
  end

  assign ours = ip_assigned && (local_ip == pkt.target_ip);
  assign full = (fill_count == CW'(TABLE_ENTRIES));

  always_comb begin
    unique case (pkt.cls)
      CLS_SHORT:   stat_next = STAT_SHORT;
      CLS_NOT_ETH: stat_next = STAT_NOT_ETH;
      CLS_NOT_IP:  stat_next = STAT_NOT_IP;
      CLS_ARP: begin
        priority if (!ours) begin
          stat_next = hit_found ? STAT_UPD_OTHER : STAT_IGNORED;
        end else if (hit_found) begin
          stat_next = STAT_UPD_OURS;
        end else if (full) begin
          stat_next = STAT_FULL;
        end else begin
          stat_next = STAT_ADDED;
        end
      end
      default: stat_next = STAT_SHORT;
    endcase
  end

  assign reply     = (pkt.cls == CLS_ARP) && ours && (pkt.opcode == OP_REQUEST);
  assign do_add    = load && (pkt.cls == CLS_ARP) && ours && !hit_found && !full;
  assign mem_we    = do_add || (load && (pkt.cls == CLS_ARP) && hit_found);
  assign mem_waddr = hit_found ? hit_idx : fill_count[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      cmp_valid  <= 1'b0;
      hit_found  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        hit_found <= 1'b0;
      end else if (state == ST_SCAN) begin
        cmp_valid <= issue;
        if (scan_hit) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
        end
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
          cmp_idx  <= scan_idx[IW-1:0];
        end
      end
      if (do_add) begin
        fill_count <= fill_count + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pkt <= q_item;
    end
  end

  // entry table: ip in the upper bits, mac in the lower
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= {pkt.sender_ip, pkt.sender_mac};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stat        <= stat_next;
      table_full  <= (stat_next == STAT_FULL);
      reply_valid <= reply;
      if (reply) begin
        reply_hw_type    <= pkt.hw_type;
        reply_proto_type <= pkt.proto_type;
        reply_hw_len     <= pkt.hw_len;
        reply_proto_len  <= pkt.proto_len;
        reply_opcode     <= OP_REPLY;
        reply_sender_mac <= local_mac;
        reply_sender_ip  <= pkt.target_ip;
        reply_target_mac <= pkt.sender_mac;
        reply_target_ip  <= pkt.sender_ip;
      end else begin
        reply_hw_type    <= '0;
        reply_proto_type <= '0;
        reply_hw_len     <= '0;
        reply_proto_len  <= '0;
        reply_opcode     <= '0;
        reply_sender_mac <= '0;
        reply_sender_ip  <= '0;
        reply_target_mac <= '0;
        reply_target_ip  <= '0;
      end
    end
  end

  assign status = stat;

endmodule

/* src/arp_receive_table_engine_unit.sv */
// a packet is popped from the queue, ARP packets walk the table, then the result is
//   registered; the table walk reads one entry per cycle and stops at the first hit
// the back end takes the next packet from the queue only once the last result is loaded
// a two-entry queue lets new packets in while the walk or the output stalls
// reset clears the configuration registers, the queue and the entry count
// ----------------------------------------------------------------------------
// arp_receive_table_engine_unit
// ARP receive engine: drops bad frames, keeps an IP-to-MAC table, answers
// requests addressed to the local interface.
// ----------------------------------------------------------------------------
module arp_receive_table_engine_unit #(
  parameter int TABLE_ENTRIES = arte_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [arte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            frame_short,
  input  logic [15:0]                     hw_type,
  input  logic [15:0]                     proto_type,
  input  logic [7:0]                      hw_len,
  input  logic [7:0]                      proto_len,
  input  logic [15:0]                     opcode,
  input  logic [47:0]                     sender_mac,
  input  logic [31:0]                     sender_ip,
  input  logic [31:0]                     target_ip,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic                            table_full,
  output logic                            reply_valid,
  output logic [15:0]                     reply_hw_type,
  output logic [15:0]                     reply_proto_type,
  output logic [7:0]                      reply_hw_len,
  output logic [7:0]                      reply_proto_len,
  output logic [15:0]                     reply_opcode,
  output logic [47:0]                     reply_sender_mac,
  output logic [31:0]                     reply_sender_ip,
  output logic [47:0]                     reply_target_mac,
  output logic [31:0]                     reply_target_ip
);
  import arte_pkg::*;

  logic [31:0] local_ip;
  logic        ip_assigned;
  logic [47:0] local_mac;

  logic        q_full;
  logic        q_push;
  pkt_t        q_item_in;
  logic        q_pop;
  logic        q_valid;
  pkt_t        q_item_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= '0;
      ip_assigned <= 1'b0;
      local_mac   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_IP:    local_ip    <= cfg_data[31:0];
        REG_IP_ASSIGNED: ip_assigned <= cfg_data[0];
        REG_LOCAL_MAC:   local_mac   <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  arte_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_short(frame_short),
    .hw_type    (hw_type),
    .proto_type (proto_type),
    .hw_len     (hw_len),
    .proto_len  (proto_len),
    .opcode     (opcode),
    .sender_mac (sender_mac),
    .sender_ip  (sender_ip),
    .target_ip  (target_ip),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item_in)
  );

  arte_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (q_item_in),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .item_out(q_item_out)
  );

  arte_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item_out),
    .q_pop           (q_pop),
    .local_ip        (local_ip),
    .ip_assigned     (ip_assigned),
    .local_mac       (local_mac),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .table_full      (table_full),
    .reply_valid     (reply_valid),
    .reply_hw_type   (reply_hw_type),
    .reply_proto_type(reply_proto_type),
    .reply_hw_len    (reply_hw_len),
    .reply_proto_len (reply_proto_len),
    .reply_opcode    (reply_opcode),
    .reply_sender_mac(reply_sender_mac),
    .reply_sender_ip (reply_sender_ip),
    .reply_target_mac(reply_target_mac),
    .reply_target_ip (reply_target_ip)
  );

endmodule

/* src/arte_checker.sv */
// ----------------------------------------------------------------------------
// arte_checker
// Port-level checks on the results of the ARP receive table engine.
// ----------------------------------------------------------------------------
module arte_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        table_full,
  input logic        reply_valid,
  input logic [15:0] reply_hw_type,
  input logic [15:0] reply_proto_type,
  input logic [15:0] reply_opcode,
  input logic [47:0] reply_target_mac
);
  import arte_pkg::*;

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (table_full == (status == STAT_FULL)))
    else $error("table_full does not match status");

  a_reply_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |->
      (status == STAT_UPD_OURS) || (status == STAT_ADDED) || (status == STAT_FULL))
    else $error("reply for a packet not addressed to us");

  a_reply_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |->
      (reply_opcode == OP_REPLY) && (reply_hw_type == HW_TYPE_ETH) &&
      (reply_proto_type == PROTO_IPV4))
    else $error("reply header fields wrong");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reply_valid |-> (reply_opcode == '0) && (reply_target_mac == '0))
    else $error("reply fields not cleared without reply");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(reply_valid))
    else $error("result changed while stalled");

endmodule

bind arp_receive_table_engine_unit arte_checker u_arte_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .table_full      (table_full),
  .reply_valid     (reply_valid),
  .reply_hw_type   (reply_hw_type),
  .reply_proto_type(reply_proto_type),
  .reply_opcode    (reply_opcode),
  .reply_target_mac(reply_target_mac)
);

/* test/arp_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_scoreboard_pkg
// Scoreboard for the ARP receive table engine. It keeps its own copy of the
// IP-to-MAC table and the interface registers, works out the verdict for
// every accepted packet and compares each delivered verdict, field by field,
// with the oldest one outstanding.
// ----------------------------------------------------------------------------
package arp_scoreboard_pkg;
  import arte_pkg::*;

  localparam int TABLE_SLOTS = DEF_TABLE_ENTRIES;

  typedef struct packed {
    logic        frame_short;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arp_packet_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        table_full;
    logic        reply_valid;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } arp_verdict_t;

  class arp_scoreboard;
    bit          slot_used [TABLE_SLOTS];
    logic [31:0] slot_ip   [TABLE_SLOTS];
    logic [47:0] slot_mac  [TABLE_SLOTS];
    int          slots_filled;
    logic [31:0] local_ip;
    logic        ip_assigned;
    logic [47:0] local_mac;
    arp_verdict_t verdict_q[$];
    int          errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_ip[i]   = '0;
        slot_mac[i]  = '0;
      end
      slots_filled = 0;
      local_ip     = '0;
      ip_assigned  = 1'b0;
      local_mac    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOCAL_IP: begin
          local_ip = data[31:0];
        end
        REG_IP_ASSIGNED: begin
          ip_assigned = data[0];
        end
        REG_LOCAL_MAC: begin
          local_mac = data[47:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void predict_verdict(arp_packet_t p);
      arp_verdict_t v;
      int hit;
      int slot;
      bit ours;
      bit answer;
      v = '0;
      answer = 1'b0;
      if (p.frame_short) begin
        v.status = STAT_SHORT;
      end else if (p.hw_type != HW_TYPE_ETH) begin
        v.status = STAT_NOT_ETH;
      end else if (p.proto_type != PROTO_IPV4) begin
        v.status = STAT_NOT_IP;
      end else begin
        hit = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (hit < 0 && slot_used[i] && slot_ip[i] == p.sender_ip) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          slot_mac[hit] = p.sender_mac;
        end
        ours = ip_assigned && (local_ip == p.target_ip);
        if (!ours) begin
          v.status = (hit >= 0) ? STAT_UPD_OTHER : STAT_IGNORED;
        end else begin
          if (hit >= 0) begin
            v.status = STAT_UPD_OURS;
          end else begin
            slot = -1;
            if (slots_filled < TABLE_SLOTS) begin
              for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot < 0 && !slot_used[i]) begin
                  slot = i;
                end
              end
            end
            if (slot >= 0) begin
              slot_used[slot] = 1'b1;
              slot_ip[slot]   = p.sender_ip;
              slot_mac[slot]  = p.sender_mac;
              slots_filled++;
              v.status = STAT_ADDED;
            end else begin
              v.status = STAT_FULL;
            end
          end
          answer = (p.opcode == OP_REQUEST);
        end
      end
      v.table_full = (v.status == STAT_FULL);
      if (answer) begin
        v.reply_valid = 1'b1;
        v.hw_type     = p.hw_type;
        v.proto_type  = p.proto_type;
        v.hw_len      = p.hw_len;
        v.proto_len   = p.proto_len;
        v.opcode      = OP_REPLY;
        v.sender_mac  = local_mac;
        v.sender_ip   = p.target_ip;
        v.target_mac  = p.sender_mac;
        v.target_ip   = p.sender_ip;
      end
      verdict_q.push_back(v);
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_field(string name, logic [47:0] got, logic [47:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    task check_verdict(arp_verdict_t got);
      arp_verdict_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch("result delivered with no packet outstanding");
        return;
      end
      want = verdict_q.pop_front();
      check_field("status", 48'(got.status), 48'(want.status));
      check_field("table_full", 48'(got.table_full), 48'(want.table_full));
      check_field("reply_valid", 48'(got.reply_valid), 48'(want.reply_valid));
      check_field("reply_hw_type", 48'(got.hw_type), 48'(want.hw_type));
      check_field("reply_proto_type", 48'(got.proto_type), 48'(want.proto_type));
      check_field("reply_hw_len", 48'(got.hw_len), 48'(want.hw_len));
      check_field("reply_proto_len", 48'(got.proto_len), 48'(want.proto_len));
      check_field("reply_opcode", 48'(got.opcode), 48'(want.opcode));
      check_field("reply_sender_mac", got.sender_mac, want.sender_mac);
      check_field("reply_sender_ip", 48'(got.sender_ip), 48'(want.sender_ip));
      check_field("reply_target_mac", got.target_mac, want.target_mac);
      check_field("reply_target_ip", 48'(got.target_ip), 48'(want.target_ip));
    endtask
  endclass

endpackage

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives ARP packets into the receive table engine with random gaps on both
// handshakes. A directed set covers drops, updates, additions and replies;
// random phases follow under several interface settings and fill the table
// until new senders are refused.
// ----------------------------------------------------------------------------
module testbench;
  import arte_pkg::*;
  import arp_scoreboard_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 275;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic frame_short = 1'b0;
  logic [15:0] hw_type = '0;
  logic [15:0] proto_type = '0;
  logic [7:0] hw_len = '0;
  logic [7:0] proto_len = '0;
  logic [15:0] opcode = '0;
  logic [47:0] sender_mac = '0;
  logic [31:0] sender_ip = '0;
  logic [31:0] target_ip = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic table_full;
  logic reply_valid;
  logic [15:0] reply_hw_type;
  logic [15:0] reply_proto_type;
  logic [7:0] reply_hw_len;
  logic [7:0] reply_proto_len;
  logic [15:0] reply_opcode;
  logic [47:0] reply_sender_mac;
  logic [31:0] reply_sender_ip;
  logic [47:0] reply_target_mac;
  logic [31:0] reply_target_ip;

  arp_scoreboard sb = new();
  logic [31:0] sender_pool [POOL_SIZE];
  logic [31:0] cur_local_ip = '0;
  int send_burst = 0;

  arp_receive_table_engine_unit DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 90) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic arp_packet_t make_packet(logic fs, logic [15:0] ht, logic [15:0] pt,
                                              logic [7:0] hl, logic [7:0] pl,
                                              logic [15:0] op, logic [47:0] smac,
                                              logic [31:0] sip, logic [31:0] tip);
    arp_packet_t p;
    p.frame_short = fs;
    p.hw_type     = ht;
    p.proto_type  = pt;
    p.hw_len      = hl;
    p.proto_len   = pl;
    p.opcode      = op;
    p.sender_mac  = smac;
    p.sender_ip   = sip;
    p.target_ip   = tip;
    return p;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic arp_packet_t random_packet();
    arp_packet_t p;
    int r;
    p = make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST, rand48(),
                    sender_pool[$urandom_range(0, POOL_SIZE - 1)], cur_local_ip);
    if ($urandom_range(0, 99) < 18) begin
      p.frame_short = 1'($urandom);
      if ($urandom_range(0, 1)) p.hw_type = 16'($urandom);
      if ($urandom_range(0, 1)) p.proto_type = 16'($urandom);
    end
    if ($urandom_range(0, 99) < 30) begin
      p.hw_len    = 8'($urandom);
      p.proto_len = 8'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r >= 85) begin
      p.opcode = 16'($urandom);
    end else if (r >= 60) begin
      p.opcode = OP_REPLY;
    end
    if ($urandom_range(0, 99) < 15) p.sender_ip = $urandom;
    if ($urandom_range(0, 99) < 35) p.target_ip = $urandom;
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [31:0] ip, logic ip_on, logic [47:0] mac, bit stray);
    write_reg(REG_LOCAL_IP, {16'($urandom), ip});
    write_reg(REG_IP_ASSIGNED, {47'({$urandom, $urandom}), ip_on});
    write_reg(REG_LOCAL_MAC, mac);
    if (stray) write_reg(REG_UNUSED, rand48());
    cfg_we <= 1'b0;
    cur_local_ip = ip;
  endtask

  task automatic send_packet(arp_packet_t p);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    frame_short <= p.frame_short;
    hw_type     <= p.hw_type;
    proto_type  <= p.proto_type;
    hw_len      <= p.hw_len;
    proto_len   <= p.proto_len;
    opcode      <= p.opcode;
    sender_mac  <= p.sender_mac;
    sender_ip   <= p.sender_ip;
    target_ip   <= p.target_ip;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_verdict(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result side: random stalls, one verdict per transaction
  initial begin
    int burst;
    int gap;
    arp_verdict_t got;
    burst = 0;
    while (rst) @(negedge clk);
    forever begin
      gap = pick_gap(burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status      = status;
      got.table_full  = table_full;
      got.reply_valid = reply_valid;
      got.hw_type     = reply_hw_type;
      got.proto_type  = reply_proto_type;
      got.hw_len      = reply_hw_len;
      got.proto_len   = reply_proto_len;
      got.opcode      = reply_opcode;
      got.sender_mac  = reply_sender_mac;
      got.sender_ip   = reply_sender_ip;
      got.target_mac  = reply_target_mac;
      got.target_ip   = reply_target_ip;
      sb.check_verdict(got);
      @(negedge clk);
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] lip;
    logic [31:0] other_ip;
    foreach (sender_pool[i]) sender_pool[i] = $urandom;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    lip = $urandom;
    other_ip = ~lip;
    program_regs(lip, 1'b1, rand48(), 1'b0);

    // drops, checked in order short, hardware type, protocol type
    send_packet(make_packet(1'b1, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    send_packet(make_packet(1'b1, 16'h0000, 16'h0000, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    send_packet(make_packet(1'b0, 16'h0000, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    send_packet(make_packet(1'b0, 16'hffff, 16'hffff, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, 16'h0806, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, 16'h0000, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, 16'hffff, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], lip));
    // a dropped sender must still be unknown
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], other_ip));
    // unknown sender, not for us, then add, update ours, update other
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[0], other_ip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'h00, 8'h00, OP_REQUEST,
                            48'h0, sender_pool[0], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'hff, 8'hff, OP_REQUEST,
                            48'hffff_ffff_ffff, sender_pool[0], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[0], other_ip));
    // not a request: table work but no reply; the requests after it reply when ours
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REPLY,
                            rand48(), sender_pool[1], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, 16'h0000,
                            rand48(), 32'h0000_0000, lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, 16'hffff,
                            rand48(), 32'hffff_ffff, lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), 32'hffff_ffff, lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), 32'h0000_0000, 32'h0000_0000));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), $urandom, 32'hffff_ffff));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[2], lip));
    send_packet(make_packet(1'b0, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                            rand48(), sender_pool[3], other_ip));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: program_regs($urandom, 1'b1, rand48(), 1'b0);
        1: program_regs(32'h0000_0000, 1'b1, 48'h0, 1'b0);
        2: program_regs(32'hffff_ffff, 1'b1, 48'hffff_ffff_ffff, 1'b1);
        3: program_regs($urandom, 1'b0, rand48(), 1'b0);
        4: program_regs($urandom, 1'b1, rand48(), 1'b1);
        default: program_regs(sender_pool[0], 1'b1, rand48(), 1'b0);
      endcase
      repeat (PHASE_ITEMS) send_packet(random_packet());
    end

    drain();
    repeat (40) @(negedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
